@@ sv/amu_pkg.sv @@
// ----------------------------------------------------------------------------
// amu_pkg
// Types, codes and constant tables for the affine transform matrix unit.
// ----------------------------------------------------------------------------
`default_nettype none

package amu_pkg;

	typedef enum logic [2:0] {
		KIND_IDENT = 3'd0,
		KIND_POINT = 3'd1,
		KIND_TRANS = 3'd2,
		KIND_SCALE = 3'd3,
		KIND_ROTX  = 3'd4,
		KIND_ROTY  = 3'd5,
		KIND_ROTZ  = 3'd6,
		KIND_BASIS = 3'd7
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic signed [31:0] up_x;
		logic signed [31:0] up_y;
		logic signed [31:0] up_z;
		logic signed [31:0] fwd_x;
		logic signed [31:0] fwd_y;
		logic signed [31:0] fwd_z;
		logic signed [31:0] angle;
	} cmd_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
	} res_item_t;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_LOAD,
		DP_CSTART,
		DP_MUL,
		DP_ACC,
		DP_WB,
		DP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] row;
		logic [1:0] slot;
		logic [1:0] term;
	} dp_cmd_t;

	typedef struct packed {
		logic cordic_done;
		logic out_free;
	} dp_stat_t;

	localparam int OneQ16 = 65536;
	localparam int AccW = 52;
	localparam int CordicIdxW = 5;
	localparam int CordicMaxSteps = 30;
	localparam logic [31:0] FullTurn = 32'd23592960;
	localparam logic signed [33:0] HalfTurn = 34'sd11796480;
	localparam logic signed [33:0] QuarterTurn = 34'sd5898240;
	localparam logic signed [27:0] DegToRad = 28'sd74961321;
	localparam logic signed [33:0] CordicGain = 34'sd652032874;

	function automatic logic signed [33:0] atan_q30(input logic [CordicIdxW-1:0] i);
		logic signed [33:0] v;
		case (i)
			5'd0: v = 34'sd843314857;
			5'd1: v = 34'sd497837829;
			5'd2: v = 34'sd263043837;
			5'd3: v = 34'sd133525159;
			5'd4: v = 34'sd67021687;
			5'd5: v = 34'sd33543516;
			5'd6: v = 34'sd16775851;
			5'd7: v = 34'sd8388437;
			5'd8: v = 34'sd4194283;
			5'd9: v = 34'sd2097149;
			default: v = 34'sd1 <<< (5'd30 - i);
		endcase
		return v;
	endfunction

	function automatic logic [1:0] n_terms(input kind_t k);
		logic [1:0] n;
		unique case (k)
			KIND_SCALE: n = 2'd1;
			KIND_ROTX, KIND_ROTY, KIND_ROTZ: n = 2'd2;
			default: n = 2'd3;
		endcase
		return n;
	endfunction

	function automatic logic [1:0] n_slots(input kind_t k);
		logic [1:0] n;
		unique case (k)
			KIND_SCALE, KIND_BASIS: n = 2'd3;
			KIND_ROTX, KIND_ROTY, KIND_ROTZ: n = 2'd2;
			default: n = 2'd1;
		endcase
		return n;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
		logic signed [31:0] r;
		if (v > $signed({{(AccW-31){1'b0}}, {31{1'b1}}}))
			r = 32'sh7fffffff;
		else if (v < $signed({{(AccW-31){1'b1}}, {31{1'b0}}}))
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

`default_nettype wire

@@ sv/amu_cordic.sv @@
// ----------------------------------------------------------------------------
// amu_cordic
// Angle reduction and iterative rotation-mode CORDIC giving sine and cosine.
// ----------------------------------------------------------------------------
`default_nettype none

module amu_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] angle,
	output logic                    done,
	output logic signed [17:0]      sin_v,
	output logic signed [17:0]      cos_v
);

	localparam int NSteps = (CORDIC_STEPS > amu_pkg::CordicMaxSteps) ?
		amu_pkg::CordicMaxSteps : CORDIC_STEPS;
	localparam logic [amu_pkg::CordicIdxW-1:0] LastIdx = amu_pkg::CordicIdxW'(NSteps - 1);

	typedef enum logic [2:0] {C_IDLE, C_RED, C_FOLD, C_CONV, C_INIT, C_ITER, C_FIN} cst_t;

	cst_t                             state_q;
	logic [31:0]                      mag_q;
	logic                             sgn_q;
	logic [2:0]                       k_q;
	logic signed [23:0]               r_q;
	logic                             neg_q;
	logic signed [51:0]               zp_q;
	logic signed [33:0]               x_q, y_q, z_q;
	logic [amu_pkg::CordicIdxW-1:0]   i_q;
	logic                             done_q;
	logic signed [17:0]               sin_q, cos_q;

	logic [31:0]        sub;
	logic signed [33:0] r0, r1, r2;
	logic               fneg;
	logic signed [33:0] xs, ys, at;
	logic signed [17:0] cq, sq;

	function automatic logic signed [17:0] to_q16(input logic signed [33:0] v);
		logic signed [33:0] t;
		logic signed [19:0] r;
		t = (v + 34'sd8192) >>> 14;
		r = t[19:0];
		if (r > 20'sd65536) r = 20'sd65536;
		if (r < -20'sd65536) r = -20'sd65536;
		return r[17:0];
	endfunction

	always_comb begin
		sub = amu_pkg::FullTurn << k_q;
		r0 = sgn_q ? -$signed({2'b00, mag_q}) : $signed({2'b00, mag_q});
		r1 = r0;
		if (r1 >= amu_pkg::HalfTurn) r1 = r1 - 2 * amu_pkg::HalfTurn;
		if (r1 < -amu_pkg::HalfTurn) r1 = r1 + 2 * amu_pkg::HalfTurn;
		r2 = r1;
		fneg = 1'b0;
		if (r1 > amu_pkg::QuarterTurn) begin
			r2 = r1 - amu_pkg::HalfTurn;
			fneg = 1'b1;
		end else if (r1 < -amu_pkg::QuarterTurn) begin
			r2 = r1 + amu_pkg::HalfTurn;
			fneg = 1'b1;
		end
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = amu_pkg::atan_q30(i_q);
		cq = to_q16(x_q);
		sq = to_q16(y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						mag_q   <= angle[31] ? (~angle + 32'd1) : angle;
						sgn_q   <= angle[31];
						k_q     <= 3'd6;
						state_q <= C_RED;
					end
				end
				C_RED: begin
					if (mag_q >= sub) mag_q <= mag_q - sub;
					if (k_q == 3'd0) state_q <= C_FOLD;
					else k_q <= k_q - 3'd1;
				end
				C_FOLD: begin
					r_q     <= r2[23:0];
					neg_q   <= fneg;
					state_q <= C_CONV;
				end
				C_CONV: begin
					zp_q    <= r_q * amu_pkg::DegToRad;
					state_q <= C_INIT;
				end
				C_INIT: begin
					z_q     <= 34'(zp_q >>> 18);
					x_q     <= amu_pkg::CordicGain;
					y_q     <= '0;
					i_q     <= '0;
					state_q <= C_ITER;
				end
				C_ITER: begin
					if (!z_q[33]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + at;
					end
					if (i_q == LastIdx) state_q <= C_FIN;
					else i_q <= i_q + 1'b1;
				end
				C_FIN: begin
					cos_q   <= neg_q ? -cq : cq;
					sin_q   <= neg_q ? -sq : sq;
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign sin_v = sin_q;
	assign cos_v = cos_q;

endmodule

`default_nettype wire

@@ sv/amu_datapath.sv @@
// ----------------------------------------------------------------------------
// amu_datapath
// Matrix store, shared multiplier, accumulator, result buffer and output.
// ----------------------------------------------------------------------------
`default_nettype none

module amu_datapath #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire amu_pkg::cmd_item_t  cmd,
	input  wire amu_pkg::dp_cmd_t    dcmd,
	output amu_pkg::dp_stat_t        stat,
	output amu_pkg::res_item_t       res,
	output logic                     res_valid,
	input  wire logic                res_stall
);

	amu_pkg::cmd_item_t             item_q;
	logic signed [31:0]             m_q [16];
	logic signed [63:0]             prod_s1;
	logic                           neg_s1;
	logic signed [amu_pkg::AccW-1:0] acc_q;
	logic signed [31:0]             buf_q [3];
	logic                           res_valid_q;
	amu_pkg::res_item_t             res_q;

	logic                           cdone;
	logic signed [17:0]             sin_v, cos_v;
	logic [1:0]                     a_col, ca, cb;
	logic signed [31:0]             b_val;
	logic                           neg;
	logic signed [amu_pkg::AccW-1:0] bias, tv, acc_next;
	logic [1:0]                     dest;
	logic                           biased;

	amu_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (dcmd.op == amu_pkg::DP_CSTART),
		.angle (item_q.angle),
		.done  (cdone),
		.sin_v (sin_v),
		.cos_v (cos_v)
	);

	function automatic logic signed [31:0] pick(input logic [1:0] j,
		input logic signed [31:0] a, input logic signed [31:0] b,
		input logic signed [31:0] c);
		logic signed [31:0] v;
		case (j)
			2'd0: v = a;
			2'd1: v = b;
			default: v = c;
		endcase
		return v;
	endfunction

	function automatic logic [1:0] wcol(input amu_pkg::kind_t k, input logic [1:0] j,
		input logic [1:0] pa, input logic [1:0] pb);
		logic [1:0] c;
		unique case (k)
			amu_pkg::KIND_TRANS, amu_pkg::KIND_POINT: c = 2'd3;
			amu_pkg::KIND_ROTX, amu_pkg::KIND_ROTY, amu_pkg::KIND_ROTZ:
				c = (j == 2'd0) ? pa : pb;
			default: c = j;
		endcase
		return c;
	endfunction

	always_comb begin
		unique case (item_q.kind)
			amu_pkg::KIND_ROTX: begin ca = 2'd1; cb = 2'd2; end
			amu_pkg::KIND_ROTY: begin ca = 2'd2; cb = 2'd0; end
			default:            begin ca = 2'd0; cb = 2'd1; end
		endcase
		neg = 1'b0;
		unique case (item_q.kind)
			amu_pkg::KIND_SCALE: begin
				a_col = dcmd.slot;
				b_val = pick(dcmd.slot, item_q.vec_x, item_q.vec_y, item_q.vec_z);
			end
			amu_pkg::KIND_BASIS: begin
				a_col = dcmd.term;
				case (dcmd.term)
					2'd0: b_val = pick(dcmd.slot, item_q.vec_x, item_q.vec_y, item_q.vec_z);
					2'd1: b_val = pick(dcmd.slot, item_q.up_x, item_q.up_y, item_q.up_z);
					default: b_val = pick(dcmd.slot, item_q.fwd_x, item_q.fwd_y,
						item_q.fwd_z);
				endcase
			end
			amu_pkg::KIND_ROTX, amu_pkg::KIND_ROTY, amu_pkg::KIND_ROTZ: begin
				if (dcmd.term == 2'd0) begin
					a_col = (dcmd.slot == 2'd0) ? ca : cb;
					b_val = {{14{cos_v[17]}}, cos_v};
				end else begin
					a_col = (dcmd.slot == 2'd0) ? cb : ca;
					b_val = {{14{sin_v[17]}}, sin_v};
					neg   = (dcmd.slot != 2'd0);
				end
			end
			default: begin
				a_col = dcmd.term;
				b_val = pick(dcmd.term, item_q.vec_x, item_q.vec_y, item_q.vec_z);
			end
		endcase
		biased = (item_q.kind == amu_pkg::KIND_POINT) || (item_q.kind == amu_pkg::KIND_TRANS);
		bias = biased ? amu_pkg::AccW'(m_q[{2'd3, dcmd.row}]) : '0;
		tv = amu_pkg::AccW'(prod_s1 >>> 16);
		acc_next = ((dcmd.term == 2'd0) ? bias : acc_q) + (neg_s1 ? -tv : tv);
		dest = (item_q.kind == amu_pkg::KIND_POINT) ? dcmd.row : dcmd.slot;
	end

	always_ff @(posedge clk) begin
		if (dcmd.op == amu_pkg::DP_LOAD) item_q <= cmd;
		if (dcmd.op == amu_pkg::DP_MUL) begin
			prod_s1 <= m_q[{a_col, dcmd.row}] * b_val;
			neg_s1  <= neg;
		end
		if (dcmd.op == amu_pkg::DP_ACC) begin
			acc_q       <= acc_next;
			buf_q[dest] <= amu_pkg::sat32(acc_next);
		end
		if (dcmd.op == amu_pkg::DP_OUT) begin
			res_q.out_x <= buf_q[0];
			res_q.out_y <= buf_q[1];
			res_q.out_z <= buf_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				m_q[i] <= (i % 5 == 0) ? 32'(amu_pkg::OneQ16) : 32'sd0;
		end else if (dcmd.op == amu_pkg::DP_LOAD && cmd.kind == amu_pkg::KIND_IDENT) begin
			for (int i = 0; i < 16; i++)
				m_q[i] <= (i % 5 == 0) ? 32'(amu_pkg::OneQ16) : 32'sd0;
		end else if (dcmd.op == amu_pkg::DP_WB) begin
			for (int j = 0; j < 3; j++)
				if (2'(j) < amu_pkg::n_slots(item_q.kind))
					m_q[{wcol(item_q.kind, 2'(j), ca, cb), dcmd.row}] <= buf_q[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (dcmd.op == amu_pkg::DP_OUT) res_valid_q <= 1'b1;
		else if (!res_stall) res_valid_q <= 1'b0;
	end

	assign stat.cordic_done = cdone;
	assign stat.out_free    = !res_valid_q || !res_stall;
	assign res              = res_q;
	assign res_valid        = res_valid_q;

endmodule

`default_nettype wire

@@ sv/amu_ctrl.sv @@
// ----------------------------------------------------------------------------
// amu_ctrl
// Sequencer stepping rows, result slots and product terms of each command.
// ----------------------------------------------------------------------------
`default_nettype none

module amu_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	input  wire amu_pkg::kind_t    cmd_kind,
	input  wire amu_pkg::dp_stat_t stat,
	output amu_pkg::dp_cmd_t       dcmd,
	output logic                   busy
);

	typedef enum logic [2:0] {S_IDLE, S_CSTART, S_CWAIT, S_MUL, S_ACC, S_WB, S_OUT} st_t;

	st_t            state_q;
	amu_pkg::kind_t kind_q;
	logic [1:0]     row_q, slot_q, term_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= amu_pkg::KIND_IDENT;
			row_q   <= '0;
			slot_q  <= '0;
			term_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					row_q  <= '0;
					slot_q <= '0;
					term_q <= '0;
					if (cmd_valid) begin
						kind_q <= cmd_kind;
						unique case (cmd_kind)
							amu_pkg::KIND_IDENT: state_q <= S_IDLE;
							amu_pkg::KIND_ROTX, amu_pkg::KIND_ROTY, amu_pkg::KIND_ROTZ:
								state_q <= S_CSTART;
							default: state_q <= S_MUL;
						endcase
					end
				end
				S_CSTART: state_q <= S_CWAIT;
				S_CWAIT: if (stat.cordic_done) state_q <= S_MUL;
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					state_q <= S_MUL;
					if (term_q != amu_pkg::n_terms(kind_q) - 2'd1) begin
						term_q <= term_q + 2'd1;
					end else begin
						term_q <= '0;
						if (slot_q != amu_pkg::n_slots(kind_q) - 2'd1) begin
							slot_q <= slot_q + 2'd1;
						end else if (kind_q == amu_pkg::KIND_POINT) begin
							slot_q <= '0;
							if (row_q == 2'd2) state_q <= S_OUT;
							else row_q <= row_q + 2'd1;
						end else begin
							state_q <= S_WB;
						end
					end
				end
				S_WB: begin
					slot_q <= '0;
					if (row_q == 2'd3) state_q <= S_IDLE;
					else begin
						row_q   <= row_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_OUT: if (stat.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		dcmd.row  = row_q;
		dcmd.slot = slot_q;
		dcmd.term = term_q;
		unique case (state_q)
			S_IDLE:   dcmd.op = cmd_valid ? amu_pkg::DP_LOAD : amu_pkg::DP_NOP;
			S_CSTART: dcmd.op = amu_pkg::DP_CSTART;
			S_MUL:    dcmd.op = amu_pkg::DP_MUL;
			S_ACC:    dcmd.op = amu_pkg::DP_ACC;
			S_WB:     dcmd.op = amu_pkg::DP_WB;
			S_OUT:    dcmd.op = stat.out_free ? amu_pkg::DP_OUT : amu_pkg::DP_NOP;
			default:  dcmd.op = amu_pkg::DP_NOP;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

@@ sv/affine_transform_matrix_unit_core.sv @@
// ----------------------------------------------------------------------------
// affine_transform_matrix_unit_core
// 4x4 Q16.16 transform matrix edited in place by commands; transforms points.
// ----------------------------------------------------------------------------
// channel   dir   handshake            payload
// cmd       in    cmd_valid/cmd_stall  amu_pkg::cmd_item_t
// res       out   res_valid/res_stall  amu_pkg::res_item_t
//
// One command at a time; all products go through one 32x32 multiplier, each
// product term in a multiply step and then an accumulate step. An identity
// item leaves the block idle; a point item waits for the output, and
// rotations wait for the iterative CORDIC.
// Reset loads the identity matrix at once. A result waiting on res_stall
// holds the block only when the next point result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_transform_matrix_unit_core #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire amu_pkg::cmd_item_t cmd,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output amu_pkg::res_item_t      res
);

	amu_pkg::dp_cmd_t  dcmd;
	amu_pkg::dp_stat_t stat;
	logic              busy;

	amu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_kind (cmd.kind),
		.stat     (stat),
		.dcmd     (dcmd),
		.busy     (busy)
	);

	amu_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.dcmd     (dcmd),
		.stat     (stat),
		.res      (res),
		.res_valid(res_valid),
		.res_stall(res_stall)
	);

	assign cmd_stall = busy;

endmodule

`default_nettype wire

@@ sv/amu_checker.sv @@
// ----------------------------------------------------------------------------
// amu_checker
// Port-level checks of command flow and result timing.
// ----------------------------------------------------------------------------
`default_nettype none

module amu_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               cmd_valid,
	input wire logic               cmd_stall,
	input wire amu_pkg::cmd_item_t cmd,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire amu_pkg::res_item_t res
);

	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall && cmd.kind != amu_pkg::KIND_IDENT) |=> cmd_stall)
		else $error("block not busy after a working item");

	a_ident_single: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall && cmd.kind == amu_pkg::KIND_IDENT) |=> !cmd_stall)
		else $error("identity item did not finish in one cycle");

	a_res_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd_stall))
		else $error("result appeared without an item at work");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res)))
		else $error("stalled result changed");

endmodule

bind affine_transform_matrix_unit_core amu_checker u_amu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.cmd      (cmd),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res      (res)
);

`default_nettype wire

@@ tb/sv/tb_affine_transform_matrix_unit_core.sv @@
// ----------------------------------------------------------------------------
// tb_affine_transform_matrix_unit_core
// Drives matrix commands with random idling on both channels, predicts each
// transformed point in Q16.16 with a local CORDIC, and checks every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_affine_transform_matrix_unit_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Steps = 16;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_stall;
	amu_pkg::cmd_item_t cmd = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	amu_pkg::res_item_t res;

	affine_transform_matrix_unit_core #(.CORDIC_STEPS(Steps)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	amu_pkg::cmd_item_t pending_cmds[$];
	amu_pkg::res_item_t expected_points[$];
	logic signed [31:0] mat[16];
	int          errors = 0;
	bit          calm = 1'b0;
	int          send_gap = 0;
	int          recv_gap = 0;
	int          sent = 0;

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint qmul(logic signed [31:0] a, logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return p >>> 16;
	endfunction

	function automatic longint arctan_q30(int i);
		longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149};
		if (i < 10)
			return tbl[i];
		return longint'(1) << (30 - i);
	endfunction

	function automatic logic signed [31:0] round_unit(longint v);
		longint r;
		r = (v + 8192) >>> 14;
		if (r > 65536)
			r = 65536;
		if (r < -65536)
			r = -65536;
		return r[31:0];
	endfunction

	task automatic sine_cosine(input logic signed [31:0] deg,
			output logic signed [31:0] s, output logic signed [31:0] c);
		longint full, r, x, y, z, nx;
		bit flip;
		full = 64'd23592960;
		r = longint'(deg) % full;
		flip = 1'b0;
		if (r >= full / 2)
			r -= full;
		if (r < -full / 2)
			r += full;
		if (r > full / 4) begin
			r -= full / 2;
			flip = 1'b1;
		end else if (r < -full / 4) begin
			r += full / 2;
			flip = 1'b1;
		end
		z = (r * 64'sd74961321) >>> 18;
		x = 652032874;
		y = 0;
		for (int i = 0; i < Steps && i < 30; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= arctan_q30(i);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += arctan_q30(i);
			end
			x = nx;
		end
		c = round_unit(x);
		s = round_unit(y);
		if (flip) begin
			c = -c;
			s = -s;
		end
	endtask

	task automatic load_identity();
		for (int i = 0; i < 16; i++)
			mat[i] = (i % 5 == 0) ? 32'sd65536 : 32'sd0;
	endtask

	task automatic rotate_columns(int a, int b, logic signed [31:0] deg);
		logic signed [31:0] s, c, va, vb;
		sine_cosine(deg, s, c);
		for (int r = 0; r < 4; r++) begin
			va = mat[a + r];
			vb = mat[b + r];
			mat[a + r] = clamp32(qmul(c, va) + qmul(s, vb));
			mat[b + r] = clamp32(qmul(c, vb) - qmul(s, va));
		end
	endtask

	task automatic apply_command(amu_pkg::cmd_item_t t);
		amu_pkg::res_item_t p;
		logic signed [31:0] o0, o1, o2;
		logic signed [31:0] pt[3];
		case (t.kind)
			amu_pkg::KIND_IDENT: load_identity();
			amu_pkg::KIND_POINT: begin
				for (int r = 0; r < 3; r++)
					pt[r] = clamp32(qmul(mat[r], t.vec_x) + qmul(mat[4 + r], t.vec_y)
						+ qmul(mat[8 + r], t.vec_z) + longint'(mat[12 + r]));
				p.out_x = pt[0];
				p.out_y = pt[1];
				p.out_z = pt[2];
				expected_points.push_back(p);
			end
			amu_pkg::KIND_TRANS:
				for (int r = 0; r < 4; r++)
					mat[12 + r] = clamp32(longint'(mat[12 + r]) + qmul(mat[r], t.vec_x)
						+ qmul(mat[4 + r], t.vec_y) + qmul(mat[8 + r], t.vec_z));
			amu_pkg::KIND_SCALE:
				for (int r = 0; r < 4; r++) begin
					mat[r] = clamp32(qmul(mat[r], t.vec_x));
					mat[4 + r] = clamp32(qmul(mat[4 + r], t.vec_y));
					mat[8 + r] = clamp32(qmul(mat[8 + r], t.vec_z));
				end
			amu_pkg::KIND_ROTX: rotate_columns(4, 8, t.angle);
			amu_pkg::KIND_ROTY: rotate_columns(8, 0, t.angle);
			amu_pkg::KIND_ROTZ: rotate_columns(0, 4, t.angle);
			default:
				for (int r = 0; r < 4; r++) begin
					o0 = mat[r];
					o1 = mat[4 + r];
					o2 = mat[8 + r];
					mat[r] = clamp32(qmul(o0, t.vec_x) + qmul(o1, t.up_x) + qmul(o2, t.fwd_x));
					mat[4 + r] = clamp32(qmul(o0, t.vec_y) + qmul(o1, t.up_y)
						+ qmul(o2, t.fwd_y));
					mat[8 + r] = clamp32(qmul(o0, t.vec_z) + qmul(o1, t.up_z)
						+ qmul(o2, t.fwd_z));
				end
		endcase
	endtask

	function automatic logic signed [31:0] pick_value(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 262143)) - 32'sd131072;
			2: return $signed($urandom_range(0, 131072)) - 32'sd65536;
			default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		endcase
	endfunction

	function automatic amu_pkg::cmd_item_t make_cmd(amu_pkg::kind_t k, int mode);
		amu_pkg::cmd_item_t t;
		t.kind = k;
		t.vec_x = pick_value(mode);
		t.vec_y = pick_value(mode);
		t.vec_z = pick_value(mode);
		t.up_x = pick_value(mode);
		t.up_y = pick_value(mode);
		t.up_z = pick_value(mode);
		t.fwd_x = pick_value(mode);
		t.fwd_y = pick_value(mode);
		t.fwd_z = pick_value(mode);
		t.angle = ($urandom_range(0, 3) == 0) ? pick_value(0)
			: $signed($urandom_range(0, 47185920)) - 32'sd23592960;
		return t;
	endfunction

	always @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			apply_command(cmd);
			sent <= sent + 1;
		end
		if (!cmd_valid || !cmd_stall) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				cmd_valid <= 1'b0;
			end else if (pending_cmds.size() > 0 && arst_n) begin
				cmd <= pending_cmds.pop_front();
				cmd_valid <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0)
					send_gap <= $urandom_range(1, 16);
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (res_valid && !res_stall) begin
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, res);
				errors++;
			end else begin
				amu_pkg::res_item_t e;
				e = expected_points.pop_front();
				if (res.out_x !== e.out_x)
					$display("%0t: out_x expected %h actual %h", $realtime, e.out_x, res.out_x);
				if (res.out_y !== e.out_y)
					$display("%0t: out_y expected %h actual %h", $realtime, e.out_y, res.out_y);
				if (res.out_z !== e.out_z)
					$display("%0t: out_z expected %h actual %h", $realtime, e.out_z, res.out_z);
				if (res.out_x !== e.out_x || res.out_y !== e.out_y || res.out_z !== e.out_z)
					errors++;
			end
		end
		if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			res_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			recv_gap <= $urandom_range(0, 15);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	initial begin
		int total;
		amu_pkg::kind_t k;
		load_identity();
		pending_cmds.push_back(make_cmd(amu_pkg::KIND_POINT, 1));
		for (int i = 0; i < 8; i++) begin
			pending_cmds.push_back(make_cmd(amu_pkg::kind_t'(i), 2));
			pending_cmds.push_back(make_cmd(amu_pkg::KIND_POINT, 1));
		end
		pending_cmds.push_back(make_cmd(amu_pkg::KIND_SCALE, 3));
		pending_cmds.push_back(make_cmd(amu_pkg::KIND_POINT, 3));
		pending_cmds.push_back(make_cmd(amu_pkg::KIND_TRANS, 3));
		pending_cmds.push_back(make_cmd(amu_pkg::KIND_POINT, 0));
		pending_cmds.push_back(make_cmd(amu_pkg::KIND_BASIS, 0));
		pending_cmds.push_back(make_cmd(amu_pkg::KIND_POINT, 3));
		pending_cmds.push_back(make_cmd(amu_pkg::KIND_IDENT, 0));
		for (int i = 0; i < 700; i++) begin
			if ($urandom_range(0, 1))
				k = amu_pkg::KIND_POINT;
			else
				k = amu_pkg::kind_t'($urandom_range(0, 7));
			pending_cmds.push_back(make_cmd(k, (k == amu_pkg::KIND_POINT) ? $urandom_range(0, 3)
				: $urandom_range(1, 10) > 8 ? $urandom_range(0, 3) : 2));
		end
		total = pending_cmds.size();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (sent >= total - 150);
		calm = 1'b1;
		wait (sent == total && expected_points.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_points.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
sv/amu_pkg.sv
sv/amu_cordic.sv
sv/amu_datapath.sv
sv/amu_ctrl.sv
sv/affine_transform_matrix_unit_core.sv
sv/amu_checker.sv
tb/sv/tb_affine_transform_matrix_unit_core.sv
